@@ hdl/dwpid_pkg.sv @@
// shared types and constants for the dual wheel pid speed controller
package dwpid_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int ACC_W = 44;
	localparam int DIV_NW = 96;
	localparam int DIV_DW = 64;
	localparam int DIV_CW = 7;
	localparam int IDX_W = 3;

	localparam logic [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic [VALUE_WIDTH-1:0] INT_LIMIT = 32'd65470;

	localparam logic [IDX_W-1:0] REG_GAIN_P   = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_I   = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_D   = 3'd2;
	localparam logic [IDX_W-1:0] REG_INTERVAL = 3'd3;
	localparam logic [IDX_W-1:0] REG_TICK     = 3'd4;
	localparam logic [IDX_W-1:0] REG_CPM      = 3'd5;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHECK,
		ST_EL,
		ST_DIST_GO,
		ST_DIST_WAIT,
		ST_SPEED_GO,
		ST_SPEED_WAIT,
		ST_DERIV_GO,
		ST_DERIV_WAIT,
		ST_MP,
		ST_MI,
		ST_MD,
		ST_ML,
		ST_MH,
		ST_INC,
		ST_MT,
		ST_CLAMP,
		ST_OUT
	} state_t;

	typedef struct packed {
		state_t step;
		logic   wheel;
		logic   take;
		logic   load_out;
	} cmd_t;

	typedef struct packed {
		logic upd;
		logic div_done;
	} stat_t;

endpackage

@@ hdl/dwpid_divider.sv @@
// serial restoring divider, one quotient bit per cycle, capped result
module dwpid_divider import dwpid_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_CW-1:0] bits,
	input  logic [DIV_DW-1:0] den,
	input  logic              cap_small,
	output logic              done,
	output logic [DIV_DW-1:0] quo
);

	logic              busy_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_NW-1:0] sr_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] q_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW-1:0] quo_q;
	logic              ovf_q;
	logic              small_q;

	logic [DIV_DW:0]   r2;
	logic              ge;
	logic [DIV_DW:0]   rsub;
	logic [DIV_DW-1:0] qn;
	logic              ovn;
	logic [DIV_DW-1:0] cap_start;
	logic [DIV_DW-1:0] cap_run;

	always_comb begin
		r2 = {rem_q, sr_q[DIV_NW-1]};
		ge = r2 >= {1'b0, den_q};
		rsub = r2 - {1'b0, den_q};
		qn = {q_q[DIV_DW-2:0], ge};
		ovn = ovf_q | q_q[DIV_DW-1];
		cap_start = cap_small ? {{(DIV_DW-VALUE_WIDTH){1'b0}}, VMAX} : {DIV_DW{1'b1}};
		cap_run = small_q ? {{(DIV_DW-VALUE_WIDTH){1'b0}}, VMAX} : {DIV_DW{1'b1}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (den == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q <= bits;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sr_q <= num;
			rem_q <= '0;
			q_q <= '0;
			ovf_q <= 1'b0;
			den_q <= den;
			small_q <= cap_small;
			// zero divisor: zero over zero is zero, anything else saturates
			quo_q <= (num == '0) ? '0 : cap_start;
		end else if (busy_q) begin
			sr_q <= {sr_q[DIV_NW-2:0], 1'b0};
			rem_q <= ge ? rsub[DIV_DW-1:0] : r2[DIV_DW-1:0];
			q_q <= qn;
			ovf_q <= ovn;
			if (cnt_q == DIV_CW'(1))
				quo_q <= (ovn || (qn > cap_run)) ? cap_run : qn;
		end
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule

@@ hdl/dwpid_datapath.sv @@
// datapath: config, wheel state, shared multiplier, divider and output register
module dwpid_datapath import dwpid_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output stat_t            stat,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [31:0]      cfg_data,
	input  logic [31:0]      timer_now,
	input  logic [31:0]      right_count,
	input  logic [31:0]      left_count,
	input  logic [31:0]      right_target,
	input  logic [31:0]      left_target,
	output logic [7:0]       right_duty,
	output logic             right_reverse,
	output logic [7:0]       left_duty,
	output logic             left_forward,
	output logic             updated
);

	localparam logic [DIV_CW-1:0] NB_DIST  = 7'd64;
	localparam logic [DIV_CW-1:0] NB_SPEED = 7'd80;
	localparam logic [DIV_CW-1:0] NB_DERIV = 7'd64;
	localparam logic signed [ACC_W-1:0] VMAX_A = ACC_W'(VMAX);
	localparam logic signed [ACC_W-1:0] LIM_A = ACC_W'(INT_LIMIT);

	function automatic logic [31:0] mag32(input logic [31:0] v);
		mag32 = v[31] ? (32'd0 - v) : v;
	endfunction

	function automatic logic [31:0] mag24(input logic [23:0] v);
		mag24 = {8'd0, v[23] ? (24'd0 - v) : v};
	endfunction

	function automatic logic [31:0] sat_a(input logic signed [ACC_W-1:0] v);
		if (v > VMAX_A)
			sat_a = VMAX;
		else if (v < -VMAX_A)
			sat_a = 32'd0 - VMAX;
		else
			sat_a = v[31:0];
	endfunction

	function automatic logic [7:0] duty(input logic [31:0] c);
		logic [31:0] m;
		logic [39:0] p;
		logic [23:0] s;
		m = mag32(c);
		p = {m, 8'd0} - {8'd0, m};
		s = p[39:16];
		duty = (s > 24'd255) ? 8'd0 : (8'd255 - s[7:0]);
	endfunction

	// configuration
	logic [23:0] gp_q, gi_q, gd_q;
	logic [31:0] interval_q, tp_q;
	logic [19:0] cpm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gp_q <= '0;
			gi_q <= '0;
			gd_q <= '0;
			interval_q <= 32'd2500;
			tp_q <= 32'd18325;
			cpm_q <= 20'd57000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAIN_P:   gp_q <= cfg_data[23:0];
				REG_GAIN_I:   gi_q <= cfg_data[23:0];
				REG_GAIN_D:   gd_q <= cfg_data[23:0];
				REG_INTERVAL: interval_q <= cfg_data;
				REG_TICK:     tp_q <= cfg_data;
				REG_CPM:      cpm_q <= cfg_data[19:0];
				default:      ;
			endcase
		end
	end

	// item registers and work registers
	logic [31:0] timer_q;
	logic [31:0] cmag_q [2];
	logic        cneg_q [2];
	logic [31:0] tgt_q [2];
	logic [63:0] el_q, dist_q, mul_q;
	logic        mul_neg_q;
	logic [31:0] err_q, deriv_q, lo_q;
	logic        dneg_q, upd_q;
	logic signed [ACC_W-1:0] acc_q;

	// controller state
	logic [31:0] last_q;
	logic [31:0] prev_q [2];
	logic [31:0] integ_q [2];
	logic [31:0] ctrl_q [2];

	logic        w;
	logic [31:0] dt;
	logic        upd;
	logic [31:0] mul_a, mul_b;
	logic        mul_neg;
	logic [ACC_W-1:0] tmag;
	logic signed [ACC_W-1:0] term;
	logic signed [32:0] d33;
	logic [31:0] dmag;
	logic [31:0] quo32;
	logic [31:0] speed;
	logic signed [32:0] e33;
	logic [64:0] incm;
	logic [31:0] incc;
	logic [31:0] inc;
	logic signed [32:0] i33;

	logic              div_start, div_small, div_done;
	logic [DIV_NW-1:0] div_num;
	logic [DIV_CW-1:0] div_bits;
	logic [DIV_DW-1:0] div_den, div_quo;

	assign w = cmd.wheel;
	assign dt = timer_q - last_q;
	assign upd = dt > interval_q;
	assign stat.upd = upd;
	assign stat.div_done = div_done;

	always_comb begin
		tmag = mul_q[59:16];
		term = mul_neg_q ? -$signed(tmag) : $signed(tmag);
		d33 = $signed({err_q[31], err_q}) - $signed({prev_q[w][31], prev_q[w]});
		dmag = d33[32] ? (32'd0 - d33[31:0]) : d33[31:0];
		quo32 = div_quo[31:0];
		speed = cneg_q[w] ? (32'd0 - quo32) : quo32;
		e33 = $signed({tgt_q[w][31], tgt_q[w]}) - $signed({speed[31], speed});
		incm = {1'b0, mul_q} + {33'd0, lo_q};
		incc = (incm > {33'd0, VMAX}) ? VMAX : incm[31:0];
		inc = err_q[31] ? (32'd0 - incc) : incc;
		i33 = $signed({integ_q[w][31], integ_q[w]}) + $signed({inc[31], inc});
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		mul_neg = 1'b0;
		case (cmd.step)
			ST_CHECK: begin
				mul_a = dt;
				mul_b = tp_q;
			end
			ST_MP: begin
				mul_a = mag32(err_q);
				mul_b = mag24(gp_q);
				mul_neg = err_q[31] ^ gp_q[23];
			end
			ST_MI, ST_MT: begin
				mul_a = mag32(integ_q[w]);
				mul_b = mag24(gi_q);
				mul_neg = integ_q[w][31] ^ gi_q[23];
			end
			ST_MD: begin
				mul_a = mag32(deriv_q);
				mul_b = mag24(gd_q);
				mul_neg = deriv_q[31] ^ gd_q[23];
			end
			ST_ML: begin
				mul_a = mag32(err_q);
				mul_b = el_q[31:0];
			end
			ST_MH: begin
				mul_a = mag32(err_q);
				mul_b = el_q[63:32];
			end
			default: ;
		endcase
	end

	// divider operand select, numerators left aligned
	always_comb begin
		div_start = 1'b0;
		div_num = '0;
		div_bits = NB_DIST;
		div_den = '0;
		div_small = 1'b1;
		case (cmd.step)
			ST_DIST_GO: begin
				div_start = 1'b1;
				div_num = {cmag_q[w], 64'd0};
				div_den = {44'd0, cpm_q};
				div_small = 1'b0;
			end
			ST_SPEED_GO: begin
				div_start = 1'b1;
				div_num = {dist_q, 32'd0};
				div_bits = NB_SPEED;
				div_den = el_q;
			end
			ST_DERIV_GO: begin
				div_start = 1'b1;
				div_num = {dmag, 64'd0};
				div_bits = NB_DERIV;
				div_den = el_q;
			end
			default: ;
		endcase
	end

	dwpid_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.num       (div_num),
		.bits      (div_bits),
		.den       (div_den),
		.cap_small (div_small),
		.done      (div_done),
		.quo       (div_quo)
	);

	always_ff @(posedge clk) begin
		mul_q <= {32'd0, mul_a} * {32'd0, mul_b};
		mul_neg_q <= mul_neg;
		if (cmd.take) begin
			timer_q <= timer_now;
			cmag_q[0] <= mag32(right_count);
			cneg_q[0] <= right_count[31];
			// left count is negated before use
			cmag_q[1] <= mag32(left_count);
			cneg_q[1] <= ~left_count[31];
			tgt_q[0] <= right_target;
			tgt_q[1] <= left_target;
		end
		case (cmd.step)
			ST_CHECK: upd_q <= upd;
			ST_EL: el_q <= mul_q;
			ST_DIST_WAIT: if (div_done) dist_q <= div_quo;
			ST_SPEED_WAIT: if (div_done) err_q <= sat_a(ACC_W'(e33));
			ST_DERIV_GO: dneg_q <= d33[32];
			ST_DERIV_WAIT: if (div_done) deriv_q <= dneg_q ? (32'd0 - quo32) : quo32;
			ST_MI: acc_q <= term;
			ST_MD: acc_q <= acc_q + term;
			ST_MH: lo_q <= mul_q[63:32];
			default: ;
		endcase
		if (cmd.load_out) begin
			right_duty <= duty(ctrl_q[0]);
			right_reverse <= ctrl_q[0][31];
			left_duty <= duty(ctrl_q[1]);
			left_forward <= ~ctrl_q[1][31];
			updated <= upd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			prev_q[0] <= '0;
			prev_q[1] <= '0;
			integ_q[0] <= '0;
			integ_q[1] <= '0;
			ctrl_q[0] <= '0;
			ctrl_q[1] <= '0;
		end else begin
			case (cmd.step)
				ST_CHECK: if (upd) last_q <= timer_q;
				ST_ML: ctrl_q[w] <= sat_a(acc_q + term);
				ST_INC: integ_q[w] <= sat_a(ACC_W'(i33));
				ST_CLAMP: begin
					// anti-windup once integral times gain passes the limit
					if (term > LIM_A)
						integ_q[w] <= INT_LIMIT;
					else if (term < -LIM_A)
						integ_q[w] <= 32'd0 - INT_LIMIT;
					prev_q[w] <= err_q;
				end
				default: ;
			endcase
		end
	end

endmodule

@@ hdl/dwpid_ctrl.sv @@
// controller: sequences one item through both wheels when an update is due, and runs the handshakes
module dwpid_ctrl import dwpid_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;
	logic   wheel_q, wheel_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wheel_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			wheel_q <= wheel_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		wheel_d = wheel_q;
		in_ready = (state_q == ST_IDLE);
		cmd.step = state_q;
		cmd.wheel = wheel_q;
		cmd.take = in_valid && (state_q == ST_IDLE);
		cmd.load_out = (state_q == ST_OUT) && (!out_valid_q || out_ready);
		unique case (state_q)
			ST_IDLE:       if (in_valid) state_d = ST_CHECK;
			ST_CHECK:      state_d = stat.upd ? ST_EL : ST_OUT;
			ST_EL: begin
				wheel_d = 1'b0;
				state_d = ST_DIST_GO;
			end
			ST_DIST_GO:    state_d = ST_DIST_WAIT;
			ST_DIST_WAIT:  if (stat.div_done) state_d = ST_SPEED_GO;
			ST_SPEED_GO:   state_d = ST_SPEED_WAIT;
			ST_SPEED_WAIT: if (stat.div_done) state_d = ST_DERIV_GO;
			ST_DERIV_GO:   state_d = ST_DERIV_WAIT;
			ST_DERIV_WAIT: if (stat.div_done) state_d = ST_MP;
			ST_MP:         state_d = ST_MI;
			ST_MI:         state_d = ST_MD;
			ST_MD:         state_d = ST_ML;
			ST_ML:         state_d = ST_MH;
			ST_MH:         state_d = ST_INC;
			ST_INC:        state_d = ST_MT;
			ST_MT:         state_d = ST_CLAMP;
			ST_CLAMP: begin
				if (!wheel_q) begin
					wheel_d = 1'b1;
					state_d = ST_DIST_GO;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_OUT:        if (cmd.load_out) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

@@ hdl/dual_wheel_pid_speed_control.sv @@
// Dual wheel PID speed controller. One item at a time: an item that triggers no
// controller update goes from the check state straight to the output state; an
// item that updates runs, for each wheel in turn, through the single serial
// divider (one quotient bit per cycle) that computes distance, speed and
// derivative, plus a shared 32x32 multiplier sequence. A division by a zero
// divisor skips the bit-serial loop and reports done directly.
// A new item is taken while the previous result still waits in the output
// register; a result that is not taken holds the block once the next item is done.
module dual_wheel_pid_speed_control import dwpid_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [31:0]      cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [31:0]      timer_now,
	input  logic [31:0]      right_count,
	input  logic [31:0]      left_count,
	input  logic [31:0]      right_target,
	input  logic [31:0]      left_target,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       right_duty,
	output logic             right_reverse,
	output logic [7:0]       left_duty,
	output logic             left_forward,
	output logic             updated
);

	cmd_t  cmd;
	stat_t stat;

	dwpid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	dwpid_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.timer_now     (timer_now),
		.right_count   (right_count),
		.left_count    (left_count),
		.right_target  (right_target),
		.left_target   (left_target),
		.right_duty    (right_duty),
		.right_reverse (right_reverse),
		.left_duty     (left_duty),
		.left_forward  (left_forward),
		.updated       (updated)
	);

endmodule

@@ hdl/dwpid_checker.sv @@
// port level checks for the dual wheel pid speed controller
module dwpid_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] right_duty,
	input logic       right_reverse,
	input logic [7:0] left_duty,
	input logic       left_forward,
	input logic       updated
);

	// one item in flight: busy right after an item is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while previous item still in work");

	// a result appears only when the block goes back to waiting for an item
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result shown while block still busy");

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(right_duty) && $stable(left_duty)
			&& $stable(right_reverse) && $stable(left_forward) && $stable(updated))
		else $error("stalled result changed");

endmodule

bind dual_wheel_pid_speed_control dwpid_checker u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.right_duty    (right_duty),
	.right_reverse (right_reverse),
	.left_duty     (left_duty),
	.left_forward  (left_forward),
	.updated       (updated)
);
